// ----- rtl/core/rotate_point_about_center_unit_macros.svh -----
// Assertion macros used by the checker of this block.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef ROTATE_POINT_ABOUT_CENTER_UNIT_MACROS_SVH
`define ROTATE_POINT_ABOUT_CENTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define RPAC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent, outside reset.
`define RPAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent, reset included.
`define RPAC_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rpac_pkg.sv -----
package rpac_pkg;

  localparam int COORD_W = 24;
  localparam int ANGLE_W = 18;
  localparam int DX_W = COORD_W + 1;
  localparam int CORDIC_W = 33;
  localparam int DEG_W = 26;
  localparam int ATAN_ENTRIES = 24;
  localparam int ROUND_SHIFT = 30;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRACTION_BITS_DEF = 8;

  localparam logic signed [DEG_W-1:0] DEG_TO_RAD_Q30 = 26'sd18740330;
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam logic signed [31:0] Q30_HALF = 32'sd536870912;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  // Arctangent of 2^-i in Q2.30, truncated.
  localparam logic signed [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
    32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
    32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
    32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
    32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
    32'sd1023,      32'sd511,       32'sd255,       32'sd127
  };

  typedef struct packed {
    logic signed [DX_W-1:0]    dx;
    logic signed [DX_W-1:0]    dy;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } side_t;

endpackage

// ----- rtl/core/rotate_point_about_center_unit.sv -----
// Rotates a point about a center by an angle in degrees, one request per clock
// while results are taken. Every request passes through STEPS + 9 register
// stages, where STEPS is CORDIC_STEPS capped at 24: six reduce the angle to one
// turn, fold it into [-90, +90] degrees and scale it to radians, one stage per
// CORDIC iteration forms cosine and sine, and three form the products, round
// them and add the center back with saturation. The whole pipeline advances
// together; a result that is not taken moves into an output skid register, and
// requests are held off only while that register is full.
module rotate_point_about_center_unit
  import rpac_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      point_valid,
  output logic                      point_ready,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic signed [ANGLE_W-1:0] angle_deg,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic signed [COORD_W-1:0] rotated_x,
  output logic signed [COORD_W-1:0] rotated_y,
  output logic                      saturated
);

  localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int ST_M = 3;
  localparam int ST_F = 4;
  localparam int ST_C0 = 6;
  localparam int ST_P = ST_C0 + STEPS;
  localparam int ST_S = ST_P + 1;
  localparam int NS = ST_P + 3;

  localparam int MAG_W = ANGLE_W;
  localparam int SANG_W = ANGLE_W + 1;
  localparam int FOLD_W = ANGLE_W + 2;
  localparam int RECIP_W = 32;

  localparam int FULL_I = 360 << FRACTION_BITS;
  localparam int HALF_I = 180 << FRACTION_BITS;
  localparam int QUARTER_I = 90 << FRACTION_BITS;
  localparam int FULL_W = $clog2(FULL_I + 1);
  localparam int CMP_W = MAG_W + FULL_W;
  localparam logic [FULL_W-1:0] FULL = FULL_W'(FULL_I);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_W) / FULL_I);

  localparam int MAG_LIMIT = 1 << (ANGLE_W - 1);
  localparam logic signed [FOLD_W-1:0] HALF_L =
    FOLD_W'((HALF_I > MAG_LIMIT) ? MAG_LIMIT + 1 : HALF_I);
  localparam logic signed [FOLD_W-1:0] QUARTER_L =
    FOLD_W'((QUARTER_I > MAG_LIMIT) ? MAG_LIMIT + 1 : QUARTER_I);
  localparam logic signed [FOLD_W-1:0] FULL_L =
    FOLD_W'((HALF_I > MAG_LIMIT) ? 2 * MAG_LIMIT + 2 : FULL_I);

  localparam int ZPROD_W = SANG_W + DEG_W;
  localparam int PROD_W = DX_W + CORDIC_W;
  localparam int SUM_W = PROD_W + 1;
  localparam int SHIFT_W = SUM_W - ROUND_SHIFT;
  localparam int TOT_W = SHIFT_W + 1;

  logic              en;
  logic [NS-1:0]     vld;
  side_t             side [NS];
  side_t             side_in;
  side_t             side_neg;

  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  mag_next;
  logic              aneg0;
  logic [MAG_W-1:0]  mag1;
  logic              aneg1;
  logic [MAG_W-1:0]  quo;
  logic [MAG_W+RECIP_W-1:0] qprod;
  logic [CMP_W-1:0]  qfull;
  logic [MAG_W-1:0]  rem0;
  logic              aneg2;
  logic [MAG_W-1:0]  rem;
  logic signed [SANG_W-1:0] sang;
  logic signed [SANG_W-1:0] sang_next;
  logic signed [FOLD_W-1:0] fold_a;
  logic signed [FOLD_W-1:0] fold_b;
  logic signed [FOLD_W-1:0] fold_c;
  logic              flip;
  logic signed [SANG_W-1:0] fang;
  logic signed [ZPROD_W-1:0] zprod;
  logic signed [CORDIC_W-1:0] z_ang;

  logic signed [CORDIC_W-1:0] cor_x [STEPS];
  logic signed [CORDIC_W-1:0] cor_y [STEPS];
  logic signed [CORDIC_W-1:0] cor_z [STEPS];

  logic signed [PROD_W-1:0] pxx;
  logic signed [PROD_W-1:0] pyy;
  logic signed [PROD_W-1:0] pxy;
  logic signed [PROD_W-1:0] pyx;
  logic signed [SUM_W-1:0]  sumx;
  logic signed [SUM_W-1:0]  sumy;
  logic signed [SHIFT_W-1:0] sx;
  logic signed [SHIFT_W-1:0] sy;
  logic signed [TOT_W-1:0]  tx;
  logic signed [TOT_W-1:0]  ty;
  logic signed [COORD_W-1:0] ox_next;
  logic signed [COORD_W-1:0] oy_next;
  logic              osat_next;
  logic signed [COORD_W-1:0] ox;
  logic signed [COORD_W-1:0] oy;
  logic              osat;

  logic              skid_full;
  logic signed [COORD_W-1:0] skid_x;
  logic signed [COORD_W-1:0] skid_y;
  logic              skid_sat;

  // The pipeline moves as one; it stops only while the skid register holds a result.
  assign en = !skid_full;
  assign point_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], point_valid};
    end
  end

  // Stage 0: magnitude of the angle and the translated point.
  assign mag_next = angle_deg[ANGLE_W-1] ? unsigned'(-angle_deg) : unsigned'(angle_deg);
  assign side_in.dx = DX_W'(point_x) - DX_W'(center_x);
  assign side_in.dy = DX_W'(point_y) - DX_W'(center_y);
  assign side_in.cx = center_x;
  assign side_in.cy = center_y;

  // Stages 1 to 3: remainder of the magnitude by one turn through a reciprocal.
  assign qprod = mag * RECIP;
  assign qfull = quo * FULL;
  assign rem = (CMP_W'(rem0) >= CMP_W'(FULL)) ? rem0 - MAG_W'(FULL_I) : rem0;
  assign sang_next = aneg2 ? -signed'({1'b0, rem}) : signed'({1'b0, rem});

  // Stage 4: wrap into half a turn each way, then fold into a quarter turn.
  always_comb begin
    fold_a = FOLD_W'(sang);
    if (fold_a > HALF_L) begin
      fold_b = fold_a - FULL_L;
    end else if (fold_a < -HALF_L) begin
      fold_b = fold_a + FULL_L;
    end else begin
      fold_b = fold_a;
    end
    flip = 1'b0;
    if (fold_b > QUARTER_L) begin
      fold_c = fold_b - HALF_L;
      flip = 1'b1;
    end else if (fold_b < -QUARTER_L) begin
      fold_c = fold_b + HALF_L;
      flip = 1'b1;
    end else begin
      fold_c = fold_b;
    end
  end

  // A fold by half a turn negates cosine and sine, which is the same as
  // negating the translated point.
  assign side_neg.dx = flip ? -side[ST_M].dx : side[ST_M].dx;
  assign side_neg.dy = flip ? -side[ST_M].dy : side[ST_M].dy;
  assign side_neg.cx = side[ST_M].cx;
  assign side_neg.cy = side[ST_M].cy;

  // Stage 5: degrees to radians in Q2.30.
  assign zprod = fang * DEG_TO_RAD_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= mag_next;
      aneg0 <= angle_deg[ANGLE_W-1];
      quo <= qprod[RECIP_W +: MAG_W];
      mag1 <= mag;
      aneg1 <= aneg0;
      rem0 <= mag1 - qfull[MAG_W-1:0];
      aneg2 <= aneg1;
      sang <= sang_next;
      fang <= SANG_W'(fold_c);
      z_ang <= CORDIC_W'(zprod >>> FRACTION_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_side
    if (k == ST_F) begin : g_flip
      always_ff @(posedge clk) begin
        if (en) begin
          side[k] <= side_neg;
        end
      end
    end else begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          side[k] <= side[k-1];
        end
      end
    end
  end

  // One CORDIC iteration per stage, rotation mode.
  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    logic signed [CORDIC_W-1:0] x_in;
    logic signed [CORDIC_W-1:0] y_in;
    logic signed [CORDIC_W-1:0] z_in;
    if (i == 0) begin : g_first
      assign x_in = CORDIC_W'(CORDIC_GAIN_Q30);
      assign y_in = '0;
      assign z_in = z_ang;
    end else begin : g_next
      assign x_in = cor_x[i-1];
      assign y_in = cor_y[i-1];
      assign z_in = cor_z[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_in[CORDIC_W-1]) begin
          cor_x[i] <= x_in - (y_in >>> i);
          cor_y[i] <= y_in + (x_in >>> i);
          cor_z[i] <= z_in - CORDIC_W'(ATAN_Q30[i]);
        end else begin
          cor_x[i] <= x_in + (y_in >>> i);
          cor_y[i] <= y_in - (x_in >>> i);
          cor_z[i] <= z_in + CORDIC_W'(ATAN_Q30[i]);
        end
      end
    end
  end

  // Products, rounding, and the center added back with saturation.
  assign sumx = SUM_W'(pxx) - SUM_W'(pyy) + SUM_W'(Q30_HALF);
  assign sumy = SUM_W'(pxy) + SUM_W'(pyx) + SUM_W'(Q30_HALF);
  assign tx = TOT_W'(sx) + TOT_W'(side[ST_S].cx);
  assign ty = TOT_W'(sy) + TOT_W'(side[ST_S].cy);

  always_comb begin
    osat_next = 1'b0;
    if (tx > TOT_W'(COORD_MAX)) begin
      ox_next = COORD_MAX;
      osat_next = 1'b1;
    end else if (tx < TOT_W'(COORD_MIN)) begin
      ox_next = COORD_MIN;
      osat_next = 1'b1;
    end else begin
      ox_next = COORD_W'(tx);
    end
    if (ty > TOT_W'(COORD_MAX)) begin
      oy_next = COORD_MAX;
      osat_next = 1'b1;
    end else if (ty < TOT_W'(COORD_MIN)) begin
      oy_next = COORD_MIN;
      osat_next = 1'b1;
    end else begin
      oy_next = COORD_W'(ty);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxx <= side[ST_P-1].dx * cor_x[STEPS-1];
      pyy <= side[ST_P-1].dy * cor_y[STEPS-1];
      pxy <= side[ST_P-1].dx * cor_y[STEPS-1];
      pyx <= side[ST_P-1].dy * cor_x[STEPS-1];
      sx <= SHIFT_W'(sumx >>> ROUND_SHIFT);
      sy <= SHIFT_W'(sumy >>> ROUND_SHIFT);
      ox <= ox_next;
      oy <= oy_next;
      osat <= osat_next;
    end
  end

  // Output skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (result_ready) begin
        skid_full <= 1'b0;
      end
    end else if (vld[NS-1] && !result_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_x <= ox;
      skid_y <= oy;
      skid_sat <= osat;
    end
  end

  assign result_valid = skid_full || vld[NS-1];
  assign rotated_x = skid_full ? skid_x : ox;
  assign rotated_y = skid_full ? skid_y : oy;
  assign saturated = skid_full ? skid_sat : osat;

endmodule

// ----- rtl/core/rpac_checker.sv -----
`include "rotate_point_about_center_unit_macros.svh"

module rpac_checker
  import rpac_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      point_valid,
  input logic                      point_ready,
  input logic signed [COORD_W-1:0] point_x,
  input logic signed [COORD_W-1:0] point_y,
  input logic signed [COORD_W-1:0] center_x,
  input logic signed [COORD_W-1:0] center_y,
  input logic signed [ANGLE_W-1:0] angle_deg,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic signed [COORD_W-1:0] rotated_x,
  input logic signed [COORD_W-1:0] rotated_y,
  input logic                      saturated
);

  logic                           on_rail;
  logic                           res_wait;
  logic                           req_wait;
  logic [2*COORD_W:0]             res_word;
  logic [4*COORD_W+ANGLE_W-1:0]   req_word;

  assign on_rail = rotated_x == COORD_MAX || rotated_x == COORD_MIN ||
                   rotated_y == COORD_MAX || rotated_y == COORD_MIN;
  assign res_wait = result_valid && !result_ready;
  assign req_wait = point_valid && !point_ready;
  assign res_word = {rotated_x, rotated_y, saturated};
  assign req_word = {point_x, point_y, center_x, center_y, angle_deg};

  // A flagged result must sit on a rail of the coordinate range.
  `RPAC_ASSERT_SAME(a_sat_on_rail, result_valid && saturated, on_rail, "result not clamped")

  // Requests are held off only while a result waits.
  `RPAC_ASSERT_SAME(a_stall_has_result, !point_ready, result_valid, "stall with no result")

  // Reset leaves the pipeline empty.
  `RPAC_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !result_valid, "result shown right after reset")

  // A result not taken stays, unchanged.
  `RPAC_ASSERT_NEXT(a_result_holds, res_wait, result_valid && $stable(res_word), "result changed")

  // A request not taken stays, unchanged.
  `RPAC_ASSERT_NEXT(a_request_holds, req_wait, point_valid && $stable(req_word), "request changed")

endmodule

bind rotate_point_about_center_unit rpac_checker u_rpac_checker (.*);
